FILE: rtl/bol_pkg.sv
// Package for the bounded ordered int list: command, status, state and
// cell-control types shared by the cell chain and the top level. No dependencies.
`default_nettype none

package bol_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned InW    = 40;

  typedef enum logic [ModeW-1:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_BACK  = 3'd3,
    MODE_REM_VALUE = 3'd4,
    MODE_SEARCH    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_PUSH_BACK  = 3'd2,
    CELL_POP_FRONT  = 3'd3,
    CELL_DROP_HIT   = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic              cmp_en;
    logic [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bol_cell.sv
// One storage cell of the list chain: holds one entry, compares it with the
// broadcast operand and shifts to or from its neighbors. Uses bol_pkg.
`default_nettype none

module bol_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  wire                          clk_i,
  input  wire bol_pkg::cell_ctrl_t     ctrl_i,
  input  wire [CntW-1:0]               count_i,
  input  wire [bol_pkg::ValueW-1:0]    left_i,
  input  wire [bol_pkg::ValueW-1:0]    right_i,
  input  wire                          hit_i,
  output logic [bol_pkg::ValueW-1:0]   entry_o,
  output logic [bol_pkg::ValueW-1:0]   back_o,
  output logic                         match_o
);

  logic [bol_pkg::ValueW-1:0] entry_q, entry_d;
  logic                       match_q;
  logic                       in_use;

  assign in_use = CntW'(Idx) < count_i;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      bol_pkg::CELL_PUSH_FRONT: entry_d = left_i;
      bol_pkg::CELL_PUSH_BACK: begin
        if (count_i == CntW'(Idx)) entry_d = ctrl_i.value;
      end
      bol_pkg::CELL_POP_FRONT:  entry_d = right_i;
      bol_pkg::CELL_DROP_HIT: begin
        if (hit_i) entry_d = right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.cmp_en) match_q <= in_use && (entry_q == ctrl_i.value);
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  // masked tail entry, OR-combined across the chain
  assign back_o  = (count_i == CntW'(Idx + 1)) ? entry_q : '0;

endmodule

`default_nettype wire

FILE: rtl/bol_prefix.sv
// Log-depth inclusive prefix OR over the per-cell hit bits; marks every cell
// at or after the first match. No dependencies.
`default_nettype none

module bol_prefix #(
  parameter int unsigned N = 16
) (
  input  wire  [N-1:0] hit_i,
  output logic [N-1:0] prefix_o
);

  localparam int unsigned Levels = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [Levels+1];

  assign lvl[0] = hit_i;

  for (genvar l = 0; l < Levels; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign prefix_o = lvl[Levels];

endmodule

`default_nettype wire

FILE: rtl/bounded_ordered_int_list.sv
// Top level of the bounded ordered int list: command stream in, result stream
// out, a chain of bol_cell entries and a bol_prefix first-match resolver. Uses bol_pkg.
//
// Each command runs through two states: in S_CMP every cell compares its entry
// with the operand and registers a hit; in S_UPD the prefix-OR tree picks
// the first hit, the chain shifts in one step and the result is written to the
// output register. The next command is taken in S_UPD, as the last one commits,
// so a command is not taken while the previous one is still being compared; a
// result waiting on the output holds the chain in S_UPD. Entries beyond the count
// are never read, so no clearing pass runs after reset.
`default_nettype none

module bounded_ordered_int_list #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] mode, [34:3] value, [39:35] zero
  input  wire  [bol_pkg::InW-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // [0] found, [32:1] removed_value, [34:33] status, [35 +: CntW] entry_count
  output logic [(((36 + $clog2(DEPTH + 1)) + 6) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned OutW = (((36 + CntW) + 6) / 8) * 8;
  localparam int unsigned VW   = bol_pkg::ValueW;

  bol_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [2:0]          mode_q;
  logic [VW-1:0]       value_q;
  logic                m_tvalid_q;
  logic [OutW-1:0]     m_tdata_q, m_tdata_d;
  logic                out_free, accept, commit;
  bol_pkg::cell_ctrl_t ctrl;

  logic [VW-1:0]       entry_w [DEPTH];
  logic [VW-1:0]       back_w  [DEPTH];
  logic [DEPTH-1:0]    match_w, prefix_w;
  logic [VW-1:0]       back_val;
  logic                full, empty, any_hit;
  logic                found_d;
  logic [VW-1:0]       removed_d;
  bol_pkg::status_e    status_d;
  bol_pkg::cell_op_e   upd_op;

  assign out_free = !m_tvalid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = count_q == CntW'(DEPTH);
  assign empty    = count_q == '0;
  assign any_hit  = prefix_w[DEPTH-1];

  // cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_q;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    bol_cell #(
      .CntW(CntW),
      .Idx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .count_i(count_q),
      .left_i (left_w),
      .right_i(right_w),
      .hit_i  (prefix_w[g]),
      .entry_o(entry_w[g]),
      .back_o (back_w[g]),
      .match_o(match_w[g])
    );
  end

  bol_prefix #(
    .N(DEPTH)
  ) u_prefix (
    .hit_i   (match_w),
    .prefix_o(prefix_w)
  );

  always_comb begin
    back_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_val = back_val | back_w[i];
    end
  end

  // command decode for the update cycle
  always_comb begin
    found_d   = 1'b0;
    removed_d = '0;
    status_d  = bol_pkg::ST_OK;
    count_d   = count_q;
    upd_op    = bol_pkg::CELL_HOLD;
    case (mode_q)
      bol_pkg::MODE_ADD_FRONT, bol_pkg::MODE_ADD_BACK: begin
        if (full) begin
          status_d = bol_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          upd_op  = (mode_q == bol_pkg::MODE_ADD_FRONT) ? bol_pkg::CELL_PUSH_FRONT
                                                        : bol_pkg::CELL_PUSH_BACK;
        end
      end
      bol_pkg::MODE_REM_FRONT: begin
        if (empty) begin
          status_d = bol_pkg::ST_EMPTY;
        end else begin
          removed_d = entry_w[0];
          count_d   = count_q - 1'b1;
          upd_op    = bol_pkg::CELL_POP_FRONT;
        end
      end
      bol_pkg::MODE_REM_BACK: begin
        if (empty) begin
          status_d = bol_pkg::ST_EMPTY;
        end else begin
          removed_d = back_val;
          count_d   = count_q - 1'b1;
        end
      end
      bol_pkg::MODE_REM_VALUE: begin
        if (empty) begin
          status_d = bol_pkg::ST_EMPTY;
        end else if (any_hit) begin
          found_d = 1'b1;
          count_d = count_q - 1'b1;
          upd_op  = bol_pkg::CELL_DROP_HIT;
        end
      end
      bol_pkg::MODE_SEARCH: found_d = any_hit;
      default: found_d = 1'b0;
    endcase
  end

  always_comb begin
    m_tdata_d                  = '0;
    m_tdata_d[0]               = found_d;
    m_tdata_d[32:1]            = removed_d;
    m_tdata_d[34:33]           = status_d;
    m_tdata_d[35 +: CntW]      = count_d;
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    commit        = 1'b0;
    ctrl.op       = bol_pkg::CELL_HOLD;
    ctrl.cmp_en   = 1'b0;
    ctrl.value    = value_q;
    case (state_q)
      bol_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = bol_pkg::S_CMP;
      end
      bol_pkg::S_CMP: begin
        ctrl.cmp_en = 1'b1;
        state_d     = bol_pkg::S_UPD;
      end
      bol_pkg::S_UPD: begin
        if (out_free) begin
          commit        = 1'b1;
          ctrl.op       = upd_op;
          s_axis_tready = 1'b1;
          state_d       = s_axis_tvalid ? bol_pkg::S_CMP : bol_pkg::S_IDLE;
        end
      end
      default: state_d = bol_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bol_pkg::S_IDLE;
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) count_q <= count_d;
      if (commit) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= s_axis_tdata[2:0];
      value_q <= s_axis_tdata[34:3];
    end
    if (commit) m_tdata_q <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !full && (mode_q == bol_pkg::MODE_ADD_FRONT || mode_q == bol_pkg::MODE_ADD_BACK)
    |=> count_q == $past(count_q) + 1'b1)
    else $error("add did not grow the list");

  a_no_take_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bol_pkg::S_CMP |-> !s_axis_tready)
    else $error("command taken during compare");

  a_result_from_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == bol_pkg::S_UPD))
    else $error("result without update cycle");

endmodule

`default_nettype wire

FILE: test/tb_bounded_ordered_int_list.sv
// Testbench for bounded_ordered_int_list: drives command words on the input stream
// and checks each result word against a queue-based list shadow or a table row.
// Depends on bol_pkg and the bounded_ordered_int_list RTL only.
`timescale 1ns / 1ps

module tb_bounded_ordered_int_list;
  import bol_pkg::*;

  localparam int Depth        = 16;
  localparam int CycleLimit   = 300_000;
  localparam int ItemsPerLeg  = 450;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  typedef struct packed {
    logic        found;
    logic [31:0] removed;
    status_e     status;
    logic [4:0]  count;
  } res_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] value;
    int          reps;
    bit          typed;
    res_t        res;
  } row_t;

  localparam res_t NoRes = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  logic [31:0] shadow_list[$];
  res_t        pending_results[$];
  int          mismatch_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle = 18;
  int          recv_idle = 59;

  row_t dir_rows [22] = '{
    '{MODE_REM_FRONT, 32'h0000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_EMPTY, 5'd0}},
    '{MODE_REM_BACK,  32'hFFFF_FFFF, 1, 1'b1, '{1'b0, 32'h0, ST_EMPTY, 5'd0}},
    '{MODE_REM_VALUE, 32'hFFFF_FFFF, 1, 1'b1, '{1'b0, 32'h0, ST_EMPTY, 5'd0}},
    '{MODE_SEARCH,    32'h0000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd0}},
    '{ModeSpare6,     32'hFFFF_FFFF, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd0}},
    '{MODE_ADD_FRONT, 32'h8000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd1}},
    '{MODE_REM_FRONT, 32'h0000_0000, 1, 1'b1, '{1'b0, 32'h8000_0000, ST_OK, 5'd0}},
    '{MODE_ADD_BACK,  32'h7FFF_FFFF, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd1}},
    '{MODE_ADD_FRONT, 32'h8000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd2}},
    '{MODE_ADD_BACK,  32'h8000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd3}},
    '{MODE_SEARCH,    32'h8000_0000, 1, 1'b1, '{1'b1, 32'h0, ST_OK, 5'd3}},
    '{MODE_REM_VALUE, 32'h0000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd3}},
    '{MODE_REM_VALUE, 32'h8000_0000, 1, 1'b1, '{1'b1, 32'h0, ST_OK, 5'd2}},
    '{MODE_REM_BACK,  32'hFFFF_FFFF, 1, 1'b1, '{1'b0, 32'h8000_0000, ST_OK, 5'd1}},
    '{ModeSpare7,     32'h0000_0000, 1, 1'b1, '{1'b0, 32'h0, ST_OK, 5'd1}},
    '{MODE_ADD_BACK,  32'hA5A5_A5A5, 15, 1'b0, NoRes},
    '{MODE_ADD_FRONT, 32'h0000_0001, 1, 1'b1, '{1'b0, 32'h0, ST_FULL, 5'd16}},
    '{MODE_ADD_BACK,  32'h0000_0001, 1, 1'b1, '{1'b0, 32'h0, ST_FULL, 5'd16}},
    '{MODE_SEARCH,    32'hA5A5_A5A5, 1, 1'b0, NoRes},
    '{MODE_REM_VALUE, 32'h7FFF_FFFF, 1, 1'b1, '{1'b1, 32'h0, ST_OK, 5'd15}},
    '{MODE_REM_FRONT, 32'h0000_0000, 1, 1'b0, NoRes},
    '{MODE_REM_BACK,  32'h0000_0000, 1, 1'b0, NoRes}
  };

  bounded_ordered_int_list #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout with %0d results pending", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // position of first match from the front, -1 if absent
  function automatic int list_find(logic [31:0] v);
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (shadow_list[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic res_t list_apply(logic [2:0] mode, logic [31:0] v);
    res_t r;
    int   pos;
    r = NoRes;
    r.status = ST_OK;
    case (mode)
      MODE_ADD_FRONT: begin
        if (shadow_list.size() >= Depth) r.status = ST_FULL;
        else shadow_list.push_front(v);
      end
      MODE_ADD_BACK: begin
        if (shadow_list.size() >= Depth) r.status = ST_FULL;
        else shadow_list.push_back(v);
      end
      MODE_REM_FRONT: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else r.removed = shadow_list.pop_front();
      end
      MODE_REM_BACK: begin
        if (shadow_list.size() == 0) r.status = ST_EMPTY;
        else r.removed = shadow_list.pop_back();
      end
      MODE_REM_VALUE: begin
        if (shadow_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = list_find(v);
          if (pos >= 0) begin
            r.found = 1'b1;
            shadow_list.delete(pos);
          end
        end
      end
      MODE_SEARCH: r.found = (list_find(v) >= 0);
      default: ;
    endcase
    r.count = 5'(shadow_list.size());
    return r;
  endfunction

  task automatic send_word(input logic [2:0] mode, input logic [31:0] value,
                           input bit typed, input res_t typed_res);
    int   gap;
    res_t want;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, value, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    want = list_apply(mode, value);
    if (typed) want = typed_res;
    pending_results.push_back(want);
  endtask

  // operands biased toward present entries so searches and removals hit
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r < 4 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (r < 6) return 32'($urandom_range(4)) - 32'd2;
    if (r == 6) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_mode(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 3) return $urandom_range(1) ? ModeSpare6 : ModeSpare7;
    if (filling) begin
      if (r < 33) return MODE_ADD_FRONT;
      if (r < 63) return MODE_ADD_BACK;
      if (r < 73) return MODE_REM_FRONT;
      if (r < 81) return MODE_REM_BACK;
      if (r < 90) return MODE_REM_VALUE;
      return MODE_SEARCH;
    end
    if (r < 13) return MODE_ADD_FRONT;
    if (r < 25) return MODE_ADD_BACK;
    if (r < 48) return MODE_REM_FRONT;
    if (r < 70) return MODE_REM_BACK;
    if (r < 88) return MODE_REM_VALUE;
    return MODE_SEARCH;
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found   = m_axis_tdata[0];
      got.removed = m_axis_tdata[32:1];
      got.status  = status_e'(m_axis_tdata[34:33]);
      got.count   = m_axis_tdata[39:35];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          mismatch_cnt++;
        end
        if (got.removed !== want.removed) begin
          $display("%0t: removed_value expected %h actual %h", $time, want.removed,
                   got.removed);
          mismatch_cnt++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatch_cnt++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   got.count);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    bit filling;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        send_word(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].typed,
                  dir_rows[i].res);
      end
    end

    filling = 1'b1;
    for (int leg = 0; leg < 3; leg++) begin
      case (leg)
        0: begin send_idle = 18; recv_idle = 59; end
        1: begin send_idle = 59; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int n = 0; n < ItemsPerLeg; n++) begin
        if ((shadow_list.size() == Depth && filling) ||
            (shadow_list.size() == 0 && !filling)) begin
          if ($urandom_range(1)) filling = !filling;
        end else if ($urandom_range(49) == 0) begin
          filling = !filling;
        end
        send_word(pick_mode(filling), pick_value(), 1'b0, NoRes);
      end
    end
    s_axis_tvalid <= 1'b0;

    recv_idle = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bol_pkg.sv
rtl/bol_cell.sv
rtl/bol_prefix.sv
rtl/bounded_ordered_int_list.sv
test/tb_bounded_ordered_int_list.sv
